### src/ssq_pkg.sv
`timescale 1ns / 1ps

package ssq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int KEY_W           = 32;
	localparam int ID_W            = 6;

	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_ADD     = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;

	localparam logic [1:0] ADD_NONE   = 2'd0;
	localparam logic [1:0] ADD_QUEUED = 2'd1;
	localparam logic [1:0] ADD_FULL   = 2'd2;

	// command broadcast to every cell
	typedef enum logic [1:0] {
		OP_NOP,
		OP_INSERT,
		OP_REMOVE,
		OP_WAKE
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;   // wake tick for insert, now for wake
		logic [ID_W-1:0]  id;
	} cmd_t;

	typedef struct packed {
		logic             valid;
		logic             woken;
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} entry_t;

endpackage

### src/sorted_sleep_wakeup_queue.sv
`timescale 1ns / 1ps
// Sequence: the start transfer is captured in ST_IDLE, the wake tick is formed
//   in ST_PREP, the cell row is updated in ST_EXEC and the result is registered.
// busy is high in ST_PREP and ST_EXEC; a new item is taken only once the last
//   has passed the capture, the wake-tick adder stage and the cell row update.
// Reset: arst_n clears all slot valid and woken bits at once; queue is empty.
// The receiver cannot stall: each result is on the ports for one cycle only.

module sorted_sleep_wakeup_queue #(
	parameter int QUEUE_DEPTH = ssq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                mode,
	input  logic [ssq_pkg::ID_W-1:0]  thread_id,
	input  logic [ssq_pkg::KEY_W-1:0] ticks,
	input  logic [ssq_pkg::KEY_W-1:0] now,
	output logic                      done,
	output logic                      wake_valid,
	output logic [ssq_pkg::ID_W-1:0]  wake_thread,
	output logic [1:0]                add_status,
	output logic                      release_found
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_EXEC
	} state_t;

	state_t                    state_q;
	logic [1:0]                mode_q;
	logic [ssq_pkg::ID_W-1:0]  id_q;
	logic [ssq_pkg::KEY_W-1:0] ticks_q;
	logic [ssq_pkg::KEY_W-1:0] now_q;
	// key handed to the cells: wake tick on add, current tick otherwise
	logic [ssq_pkg::KEY_W-1:0] key_q;

	ssq_pkg::cmd_t   cmd;
	ssq_pkg::entry_t ent [QUEUE_DEPTH];
	logic            le_v [QUEUE_DEPTH];
	logic            hit_v [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] vld;

	logic full;
	logic wake_hit;

	assign busy = (state_q != ST_IDLE);

	// the row is kept packed toward the head, so the last slot tells fullness
	assign full     = ent[QUEUE_DEPTH-1].valid;
	// head is due, present and not yet woken
	assign wake_hit = le_v[0] && !ent[0].woken;

	always_comb begin
		cmd.op  = ssq_pkg::OP_NOP;
		cmd.key = key_q;
		cmd.id  = id_q;
		if (state_q == ST_EXEC) begin
			unique case (mode_q)
				ssq_pkg::MODE_TICK: cmd.op = ssq_pkg::OP_WAKE;
				ssq_pkg::MODE_ADD: begin
					if (ticks_q != '0 && !full) cmd.op = ssq_pkg::OP_INSERT;
				end
				ssq_pkg::MODE_RELEASE: cmd.op = ssq_pkg::OP_REMOVE;
				default: cmd.op = ssq_pkg::OP_NOP;
			endcase
		end
	end

	// chain of slots: besides the broadcast command, each cell sees only its neighbors
	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			ssq_pkg::entry_t l_ent;
			ssq_pkg::entry_t r_ent;
			logic            l_le;
			logic            h_in;
			if (gi == 0) begin : g_first
				assign l_ent = '0;
				assign l_le  = 1'b1;
				assign h_in  = 1'b0;
			end else begin : g_mid
				assign l_ent = ent[gi-1];
				assign l_le  = le_v[gi-1];
				assign h_in  = hit_v[gi-1];
			end
			if (gi == QUEUE_DEPTH-1) begin : g_last
				assign r_ent = '0;
			end else begin : g_inner
				assign r_ent = ent[gi+1];
			end
			ssq_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.head     ((gi == 0) ? 1'b1 : 1'b0),
				.left_ent (l_ent),
				.left_le  (l_le),
				.right_ent(r_ent),
				.hit_in   (h_in),
				.ent      (ent[gi]),
				.le       (le_v[gi]),
				.hit_out  (hit_v[gi])
			);
			assign vld[gi] = ent[gi].valid;
		end
	endgenerate

	// sequencer: latch item, form wake tick, apply to the row, post result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done          <= 1'b0;
			wake_valid    <= 1'b0;
			wake_thread   <= '0;
			add_status    <= ssq_pkg::ADD_NONE;
			release_found <= 1'b0;
		end else begin
			done          <= 1'b0;
			wake_valid    <= 1'b0;
			wake_thread   <= '0;
			add_status    <= ssq_pkg::ADD_NONE;
			release_found <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
					case (mode_q)
						ssq_pkg::MODE_TICK: begin
							if (wake_hit) begin
								wake_valid  <= 1'b1;
								wake_thread <= ent[0].id;
							end
						end
						ssq_pkg::MODE_ADD: begin
							if (ticks_q == '0)  add_status <= ssq_pkg::ADD_NONE;
							else if (full)      add_status <= ssq_pkg::ADD_FULL;
							else                add_status <= ssq_pkg::ADD_QUEUED;
						end
						ssq_pkg::MODE_RELEASE: begin
							release_found <= hit_v[QUEUE_DEPTH-1];
						end
						default: begin
							done <= 1'b1;
						end
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture and wake-tick add, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mode_q  <= mode;
			id_q    <= thread_id;
			ticks_q <= ticks;
			now_q   <= now;
		end
		if (state_q == ST_PREP) begin
			key_q <= (mode_q == ssq_pkg::MODE_ADD) ? (now_q + ticks_q) : now_q;
		end
	end

`ifndef SYNTHESIS
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result not posted three cycles after start transfer");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({wake_valid, (add_status != ssq_pkg::ADD_NONE), release_found}))
		else $error("more than one kind of result in one transfer");

	a_packed_row: assert property (@(posedge clk) disable iff (!arst_n)
		((vld >> 1) & ~vld) == '0)
		else $error("valid slots not contiguous from head");

	a_quiet_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (!wake_valid && add_status == ssq_pkg::ADD_NONE && !release_found))
		else $error("result fields active without done");

	a_full_add: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ssq_pkg::OP_INSERT) |=> $countones(vld) == $countones($past(vld)) + 1)
		else $error("insert did not grow the queue by one");
`endif

endmodule

### src/ssq_cell.sv
`timescale 1ns / 1ps

// One queue slot. Shifts right on insert, left on remove; the head slot is marked woken on wake.
module ssq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ssq_pkg::cmd_t   cmd,
	input  logic            head,      // first cell of the row
	input  ssq_pkg::entry_t left_ent,
	input  logic            left_le,
	input  ssq_pkg::entry_t right_ent,
	input  logic            hit_in,
	output ssq_pkg::entry_t ent,
	output logic            le,
	output logic            hit_out
);

	logic                      valid_q;
	logic                      woken_q;
	logic [ssq_pkg::ID_W-1:0]  id_q;
	logic [ssq_pkg::KEY_W-1:0] key_q;
	ssq_pkg::entry_t           nxt;
	ssq_pkg::entry_t           ins_ent;
	logic                      load;

	assign ent.valid = valid_q;
	assign ent.woken = woken_q;
	assign ent.id    = id_q;
	assign ent.key   = key_q;

	assign le      = valid_q && (key_q <= cmd.key);
	assign hit_out = hit_in || (valid_q && (id_q == cmd.id));

	always_comb begin
		ins_ent.valid = 1'b1;
		ins_ent.woken = 1'b0;
		ins_ent.id    = cmd.id;
		ins_ent.key   = cmd.key;
		nxt  = ent;
		load = 1'b0;
		unique case (cmd.op)
			ssq_pkg::OP_INSERT: begin
				if (!le) begin
					load = 1'b1;
					nxt  = left_le ? ins_ent : left_ent;
				end
			end
			ssq_pkg::OP_REMOVE: begin
				if (hit_out) begin
					load = 1'b1;
					nxt  = right_ent;
				end
			end
			ssq_pkg::OP_WAKE: begin
				if (head && le) begin
					load      = 1'b1;
					nxt.woken = 1'b1;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			woken_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
			woken_q <= nxt.woken;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q  <= nxt.id;
			key_q <= nxt.key;
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import ssq_pkg::*;

	// Mode value 3 is left unused by the block: no state change, all-zero result.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int         QDEPTH     = QUEUE_DEPTH_DEF;
	// Longest correct stretch without any transfer is the longest sender gap plus the
	// pipeline and a drain pause; this is many times that.
	localparam int         STALL_LIMIT = 500;
	localparam int         TAIL_CYCLES = 16;
	localparam int         MAX_REPORTS = 10;

	// Gap styles for the sender
	localparam int GAP_NONE   = 0;
	localparam int GAP_ANY    = 1;
	localparam int GAP_SPARSE = 2;

	typedef struct {
		logic [1:0]      mode;
		logic [ID_W-1:0] tid;
		logic [31:0]     dur;
		logic [31:0]     stamp;
		int unsigned     gap;    // idle cycles before this transfer
		bit              drain;  // hold off until every result is back
	} sleep_cmd_t;

	typedef struct packed {
		logic            wake_valid;
		logic [ID_W-1:0] wake_thread;
		logic [1:0]      add_status;
		logic            release_found;
	} outcome_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic [1:0]      mode = MODE_TICK;
	logic [ID_W-1:0] thread_id = '0;
	logic [31:0]     ticks = '0;
	logic [31:0]     now = '0;
	logic            busy;
	logic            done;
	logic            wake_valid;
	logic [ID_W-1:0] wake_thread;
	logic [1:0]      add_status;
	logic            release_found;

	sorted_sleep_wakeup_queue u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.thread_id     (thread_id),
		.ticks         (ticks),
		.now           (now),
		.done          (done),
		.wake_valid    (wake_valid),
		.wake_thread   (wake_thread),
		.add_status    (add_status),
		.release_found (release_found)
	);

	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the sleep queue, slot 0 is the head
	// ------------------------------------------------------------------
	logic [31:0]     sq_key   [QDEPTH];
	logic [ID_W-1:0] sq_id    [QDEPTH];
	logic            sq_woken [QDEPTH];
	int              sq_count = 0;

	sleep_cmd_t cmd_backlog[$];       // items waiting to go out
	outcome_t   pending_outcomes[$];  // predicted results, oldest first

	int unsigned issued_cnt   = 0;    // items put on the ports
	int unsigned acc_cnt      = 0;    // items taken by the block
	int          stall_cycles = 0;
	int          fail_count   = 0;
	int          gap_style    = GAP_ANY;

	// Applies one item to the shadow queue and returns the result it causes.
	function automatic outcome_t predict_queue_op(logic [1:0] op, logic [ID_W-1:0] tid,
			logic [31:0] dur, logic [31:0] t_now);
		outcome_t    r;
		logic [31:0] due;
		int          pos;
		r = '0;
		case (op)
			MODE_TICK: begin
				// only the head is looked at; a woken head blocks the rest
				if (sq_count > 0 && sq_key[0] <= t_now && !sq_woken[0]) begin
					sq_woken[0]   = 1'b1;
					r.wake_valid  = 1'b1;
					r.wake_thread = sq_id[0];
				end
			end
			MODE_ADD: begin
				if (dur == 0) begin
					r.add_status = ADD_NONE;
				end else if (sq_count >= QDEPTH) begin
					r.add_status = ADD_FULL;
				end else begin
					due = t_now + dur;  // wraps mod 2^32, compared raw
					pos = 0;
					// ties go behind earlier arrivals
					while (pos < sq_count && sq_key[pos] <= due)
						pos++;
					for (int k = sq_count; k > pos; k--) begin
						sq_key[k]   = sq_key[k-1];
						sq_id[k]    = sq_id[k-1];
						sq_woken[k] = sq_woken[k-1];
					end
					sq_key[pos]   = due;
					sq_id[pos]    = tid;
					sq_woken[pos] = 1'b0;
					sq_count++;
					r.add_status = ADD_QUEUED;
				end
			end
			MODE_RELEASE: begin
				pos = 0;
				while (pos < sq_count && sq_id[pos] != tid)
					pos++;
				if (pos < sq_count) begin
					// entry nearest the head goes, the rest close up
					for (int k = pos; k + 1 < sq_count; k++) begin
						sq_key[k]   = sq_key[k+1];
						sq_id[k]    = sq_id[k+1];
						sq_woken[k] = sq_woken[k+1];
					end
					sq_count--;
					r.release_found = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic push_cmd(input logic [1:0] m, input logic [ID_W-1:0] t,
			input logic [31:0] d, input logic [31:0] s, input bit hold_drain);
		sleep_cmd_t c;
		c.mode  = m;
		c.tid   = t;
		c.dur   = d;
		c.stamp = s;
		c.drain = hold_drain;
		case (gap_style)
			GAP_NONE:   c.gap = 0;
			GAP_SPARSE: c.gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
			default:    c.gap = $urandom_range(0, 15);
		endcase
		cmd_backlog.push_back(c);
	endtask

	// ------------------------------------------------------------------
	// Driver: inputs change on the falling edge only. A transfer on the
	// ports is held until the monitor has seen it taken.
	// ------------------------------------------------------------------
	int unsigned idle_left = 0;

	always @(negedge clk) begin
		sleep_cmd_t cur;
		if (arst_n) begin
			if (start && acc_cnt != issued_cnt) begin
				// transfer still waiting on busy
			end else if (idle_left != 0) begin
				start <= 1'b0;
				idle_left--;
			end else if (cmd_backlog.size() != 0) begin
				cur = cmd_backlog.pop_front();
				if (cur.drain && pending_outcomes.size() != 0) begin
					// pause until the block has returned everything
					cmd_backlog.push_front(cur);
					start <= 1'b0;
				end else if (cur.gap != 0) begin
					idle_left = cur.gap - 1;
					cur.gap   = 0;
					cur.drain = 1'b0;
					cmd_backlog.push_front(cur);
					start <= 1'b0;
				end else begin
					mode      <= cur.mode;
					thread_id <= cur.tid;
					ticks     <= cur.dur;
					now       <= cur.stamp;
					start     <= 1'b1;
					issued_cnt++;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: everything is sampled on the rising edge. A result is
	// checked before a transfer in the same cycle is predicted, so the
	// order of expectations follows the order of acceptance.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result with nothing expected: wv=%0b id=%0d st=%0d rf=%0b",
							$realtime, wake_valid, wake_thread, add_status, release_found);
				end else begin
					want = pending_outcomes.pop_front();
					if (wake_valid !== want.wake_valid || wake_thread !== want.wake_thread ||
							add_status !== want.add_status ||
							release_found !== want.release_found) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: mismatch exp wv=%0b id=%0d st=%0d rf=%0b, got wv=%0b id=%0d st=%0d rf=%0b",
								$realtime, want.wake_valid, want.wake_thread,
								want.add_status, want.release_found,
								wake_valid, wake_thread, add_status, release_found);
					end
				end
			end
			if (start && !busy) begin
				pending_outcomes.push_back(predict_queue_op(mode, thread_id, ticks, now));
				acc_cnt++;
			end
			if (done || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Watchdog: nothing taken and nothing returned for too long
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int              seg;
		int              n;
		int              r;
		int              pick;
		int              seg_len;
		logic [31:0]     gen_now;
		logic [31:0]     dur;
		logic [ID_W-1:0] tid;
		logic [ID_W-1:0] gen_ids[$];

		// Directed part: ordering, ties, wrap, woken head blocking, releases.
		gap_style = GAP_ANY;
		push_cmd(MODE_TICK,    6'd0,  32'd0,        32'd0,        1'b0); // empty queue
		push_cmd(MODE_ADD,     6'd9,  32'd0,        32'd100,      1'b0); // zero ticks
		push_cmd(MODE_RELEASE, 6'd9,  32'd0,        32'd0,        1'b0); // release on empty
		push_cmd(MODE_ADD,     6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0); // wake tick wraps
		push_cmd(MODE_ADD,     6'd0,  32'd1,        32'd0,        1'b0); // new head
		push_cmd(MODE_ADD,     6'd5,  32'd1,        32'd0,        1'b0); // tie, goes behind
		push_cmd(MODE_ADD,     6'd21, 32'hFFFFFFFF, 32'd0,        1'b0); // end of list
		push_cmd(MODE_TICK,    6'd63, 32'hFFFFFFFF, 32'd0,        1'b0); // head not due
		push_cmd(MODE_TICK,    6'd0,  32'd0,        32'd1,        1'b0); // wakes head
		push_cmd(MODE_TICK,    6'd0,  32'd0,        32'hFFFFFFFF, 1'b0); // woken head blocks
		push_cmd(MODE_RELEASE, 6'd5,  32'd0,        32'd0,        1'b0); // middle entry
		push_cmd(MODE_RELEASE, 6'd0,  32'd0,        32'd0,        1'b0); // woken head
		push_cmd(MODE_ADD,     6'd21, 32'd2,        32'd10,       1'b0); // duplicate id
		push_cmd(MODE_TICK,    6'd0,  32'd0,        32'd12,       1'b0); // wakes the copy
		push_cmd(MODE_RELEASE, 6'd21, 32'd0,        32'd0,        1'b1); // nearest copy only
		push_cmd(MODE_TICK,    6'd0,  32'd0,        32'hFFFFFFFF, 1'b0);
		push_cmd(MODE_RELEASE, 6'd42, 32'd0,        32'd0,        1'b0); // not queued
		push_cmd(MODE_SPARE,   6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0); // unused mode
		push_cmd(MODE_SPARE,   6'd0,  32'd0,        32'd0,        1'b0);
		push_cmd(MODE_RELEASE, 6'd63, 32'd0,        32'd0,        1'b0);
		push_cmd(MODE_TICK,    6'd0,  32'd0,        32'hFFFFFFFF, 1'b0); // due at max now
		push_cmd(MODE_RELEASE, 6'd21, 32'd0,        32'd0,        1'b0);
		push_cmd(MODE_TICK,    6'd0,  32'd0,        32'hFFFFFFFF, 1'b0); // empty again

		// Random part in segments; each opens with a drain pause. Segment 3
		// overfills the queue, segment 4 sends only releases.
		gen_now = $urandom_range(0, 1000);
		for (seg = 0; seg < 8; seg++) begin
			gap_style = (seg == 0) ? GAP_NONE : $urandom_range(GAP_NONE, GAP_SPARSE);
			seg_len   = (seg == 3 || seg == 4) ? 70 : 50;
			for (n = 0; n < seg_len; n++) begin
				gen_now = gen_now + $urandom_range(0, 8);
				if ($urandom_range(0, 49) == 0)
					gen_now = $urandom;
				r = (seg == 3) ? 0 : (seg == 4) ? 60 : $urandom_range(0, 99);
				if (r < 40) begin
					tid = ID_W'($urandom_range(0, 63));
					if (seg == 3)
						dur = $urandom_range(1000, 100000);  // stay asleep
					else begin
						case ($urandom_range(0, 9))
							0:       dur = 0;
							1:       dur = $urandom;
							default: dur = $urandom_range(1, 40);
						endcase
					end
					if (dur != 0)
						gen_ids.push_back(tid);
					push_cmd(MODE_ADD, tid, dur, gen_now, n == 0);
				end else if (r < 60) begin
					push_cmd(MODE_TICK, ID_W'($urandom_range(0, 63)), $urandom, gen_now,
						n == 0);
				end else if (r < 95) begin
					if (gen_ids.size() != 0 && $urandom_range(0, 3) != 0) begin
						pick = $urandom_range(0, gen_ids.size() - 1);
						tid  = gen_ids[pick];
						gen_ids.delete(pick);
					end else begin
						tid = ID_W'($urandom_range(0, 63));
					end
					push_cmd(MODE_RELEASE, tid, $urandom, $urandom, n == 0);
				end else begin
					push_cmd(MODE_SPARE, ID_W'($urandom_range(0, 63)), $urandom, $urandom,
						n == 0);
				end
			end
		end

		// wait for the last transfer and its result, then a short tail
		while (cmd_backlog.size() != 0 || start || pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_outcomes.size() != 0)
			fail_count++;
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
